>>> rtl/asp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package asp_pkg;

  localparam int VW      = 6;
  localparam int WGT_W   = 16;
  localparam int HEUR_W  = 16;
  localparam int DIST_W  = 24;
  localparam int STEP_W  = 10;
  localparam int EDGE_W  = 2 * VW + WGT_W;
  localparam int QKEY_W  = DIST_W + VW;

  localparam logic [DIST_W-1:0] DIST_INF = '1;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  localparam logic [1:0] FUNC_LOAD_EDGE = 2'd0;
  localparam logic [1:0] FUNC_LOAD_HEUR = 2'd1;
  localparam logic [1:0] FUNC_SEARCH    = 2'd2;
  localparam logic [1:0] FUNC_CLEAR     = 2'd3;

  localparam logic [1:0] STATUS_FOUND   = 2'd0;
  localparam logic [1:0] STATUS_UNREACH = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       edge_write;
    logic       edge_clear;
    logic       h_write;
    logic       search_init;
    logic       init_push;
    logic       scan_start;
    logic       scan_run;
    logic       rm_read;
    logic       rm_write;
    logic       g_read;
    logic       g_latch;
    logic       edge_check;
    logic       eidx_inc;
    logic       relax;
    logic       step_inc;
    logic       path_init;
    logic       path_write;
    logic       par_load;
    logic       emit_dec;
    logic       out_load;
    logic       out_path;
    logic [1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       a_bad;
    logic       b_bad;
    logic       edge_full;
    logic       q_empty;
    logic       scan_done;
    logic       v_bad;
    logic       v_is_tgt;
    logic       edges_done;
    logic       match_ok;
    logic       cur_is_src;
    logic       path_full;
    logic       par_bad;
    logic       emit_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/asp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module asp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  asp_pkg::sts_t sts_i,
  output asp_pkg::cmd_t cmd_o
);
  import asp_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE      = 18'b000000000000000001,
    S_DECODE    = 18'b000000000000000010,
    S_INIT_PUSH = 18'b000000000000000100,
    S_POP_START = 18'b000000000000001000,
    S_SCAN      = 18'b000000000000010000,
    S_RM_RD     = 18'b000000000000100000,
    S_RM_WR     = 18'b000000000001000000,
    S_POP_CHK   = 18'b000000000010000000,
    S_G_LATCH   = 18'b000000000100000000,
    S_EDGE_RD   = 18'b000000001000000000,
    S_EDGE_CHK  = 18'b000000010000000000,
    S_RELAX     = 18'b000000100000000000,
    S_PATH_WR   = 18'b000001000000000000,
    S_PATH_RD   = 18'b000010000000000000,
    S_PATH_LD   = 18'b000100000000000000,
    S_EMIT_RD   = 18'b001000000000000000,
    S_EMIT_WAIT = 18'b010000000000000000,
    S_EMIT_ONE  = 18'b100000000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.func)
          FUNC_LOAD_EDGE: begin
            if (sts_i.a_bad || sts_i.b_bad) begin
              state_d = S_IDLE;
            end else if (sts_i.edge_full) begin
              state_d = S_EMIT_ONE;
            end else begin
              cmd_o.edge_write = 1'b1;
              state_d = S_IDLE;
            end
          end
          FUNC_LOAD_HEUR: begin
            cmd_o.h_write = !sts_i.a_bad;
            state_d = S_IDLE;
          end
          FUNC_SEARCH: begin
            if (sts_i.a_bad || sts_i.b_bad) begin
              state_d = S_EMIT_ONE;
            end else begin
              cmd_o.search_init = 1'b1;
              state_d = S_INIT_PUSH;
            end
          end
          default: begin
            cmd_o.edge_clear = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_INIT_PUSH: begin
        cmd_o.init_push = 1'b1;
        state_d = S_POP_START;
      end
      S_POP_START: begin
        if (sts_i.q_empty) begin
          state_d = S_EMIT_ONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_RM_RD;
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      S_RM_RD: begin
        cmd_o.rm_read = 1'b1;
        state_d = S_RM_WR;
      end
      S_RM_WR: begin
        cmd_o.rm_write = 1'b1;
        state_d = S_POP_CHK;
      end
      S_POP_CHK: begin
        if (sts_i.v_bad) begin
          state_d = S_POP_START;
        end else begin
          cmd_o.g_read = 1'b1;
          state_d = S_G_LATCH;
        end
      end
      S_G_LATCH: begin
        cmd_o.g_latch = 1'b1;
        if (sts_i.v_is_tgt) begin
          cmd_o.path_init = 1'b1;
          state_d = S_PATH_WR;
        end else begin
          state_d = S_EDGE_RD;
        end
      end
      S_EDGE_RD: begin
        if (sts_i.edges_done) begin
          cmd_o.step_inc = 1'b1;
          state_d = S_POP_START;
        end else begin
          state_d = S_EDGE_CHK;
        end
      end
      S_EDGE_CHK: begin
        if (sts_i.match_ok) begin
          cmd_o.edge_check = 1'b1;
          state_d = S_RELAX;
        end else begin
          cmd_o.eidx_inc = 1'b1;
          state_d = S_EDGE_RD;
        end
      end
      S_RELAX: begin
        cmd_o.relax = 1'b1;
        cmd_o.eidx_inc = 1'b1;
        state_d = S_EDGE_RD;
      end
      S_PATH_WR: begin
        cmd_o.path_write = 1'b1;
        if (sts_i.cur_is_src || sts_i.path_full) begin
          state_d = S_EMIT_RD;
        end else begin
          state_d = S_PATH_RD;
        end
      end
      S_PATH_RD: begin
        state_d = S_PATH_LD;
      end
      S_PATH_LD: begin
        if (sts_i.par_bad) begin
          state_d = S_EMIT_RD;
        end else begin
          cmd_o.par_load = 1'b1;
          state_d = S_PATH_WR;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_path = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.emit_dec = 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end
      S_EMIT_ONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_status = (sts_i.func == FUNC_LOAD_EDGE) ? STATUS_FULL : STATUS_UNREACH;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/asp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module asp_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int QUEUE_DEPTH  = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  asp_pkg::cmd_t                 cmd_i,
  output asp_pkg::sts_t                 sts_o,
  input  logic [1:0]                    func_i,
  input  logic [asp_pkg::VW-1:0]        vertex_a_i,
  input  logic [asp_pkg::VW-1:0]        vertex_b_i,
  input  logic [asp_pkg::WGT_W-1:0]     edge_weight_i,
  input  logic [asp_pkg::HEUR_W-1:0]    heuristic_value_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [asp_pkg::VW-1:0]        path_vertex_o,
  output logic [asp_pkg::STEP_W-1:0]    step_count_o,
  output logic [1:0]                    status_o,
  output logic                          last_o
);
  import asp_pkg::*;

  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int PC_W = $clog2(MAX_VERTICES + 1);
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [VW:0]   VLimit   = (VW + 1)'(MAX_VERTICES);
  localparam logic [PC_W-1:0] PathLast = PC_W'(MAX_VERTICES - 1);
  localparam logic [EC_W-1:0] EdgeMax  = EC_W'(MAX_EDGES);
  localparam logic [QC_W-1:0] QueueMax = QC_W'(QUEUE_DEPTH);

  logic [1:0]        func_q;
  logic [VW-1:0]     a_q, b_q;
  logic [WGT_W-1:0]  w_q;
  logic [HEUR_W-1:0] hv_q;

  logic [EDGE_W-1:0] edge_mem_q [MAX_EDGES];
  logic [EDGE_W-1:0] edge_rd_q;
  logic [EC_W-1:0]   edge_cnt_q, eidx_q;

  logic [HEUR_W-1:0] h_mem_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] h_vld_q;
  logic [HEUR_W-1:0] h_rd_q;
  logic              h_rv_q;

  logic [DIST_W-1:0] d_mem_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] d_vld_q;
  logic [DIST_W-1:0] d_rd_q;
  logic              d_rv_q;

  logic [VW-1:0]     par_mem_q [MAX_VERTICES];
  logic [VW-1:0]     par_rd_q;
  logic [MAX_VERTICES-1:0] vis_q;

  logic [QKEY_W-1:0] q_mem_q [QUEUE_DEPTH];
  logic [QKEY_W-1:0] q_rd_q, best_q;
  logic [QC_W-1:0]   q_cnt_q, sidx_q;
  logic [QA_W-1:0]   sidx_d1_q, bidx_q;
  logic              srv_q;

  logic [VW-1:0]     v_q, n_q, cur_q;
  logic [DIST_W-1:0] g_q, nd_q;
  logic [STEP_W-1:0] steps_q;

  logic [VW-1:0]     path_mem_q [MAX_VERTICES];
  logic [VW-1:0]     pm_rd_q;
  logic [PC_W-1:0]   pcnt_q, k_q;

  logic              out_valid_q;
  logic [VW-1:0]     pv_q;
  logic [STEP_W-1:0] sc_q;
  logic [1:0]        st_q;
  logic              last_q;

  logic [VW-1:0]     ea, eb, n_c;
  logic [WGT_W-1:0]  ew;
  logic              e_match;
  logic [DIST_W:0]   nd_sum, f_sum;
  logic [DIST_W-1:0] nd_c, f_c, d_eff;
  logic [HEUR_W-1:0] h_eff;
  logic              improve, q_full;
  logic [VA_W-1:0]   h_raddr, d_raddr;
  logic              q_we;
  logic [QA_W-1:0]   q_waddr, q_raddr;
  logic [QKEY_W-1:0] q_wdata;
  logic              d_we;
  logic [VA_W-1:0]   d_waddr;
  logic [DIST_W-1:0] d_wdata;
  logic [VW-1:0]     par_wdata;

  assign ea = edge_rd_q[EDGE_W-1 -: VW];
  assign eb = edge_rd_q[EDGE_W-VW-1 -: VW];
  assign ew = edge_rd_q[WGT_W-1:0];
  assign e_match = (ea == v_q) || (eb == v_q);
  assign n_c = (ea == v_q) ? eb : ea;

  assign nd_sum = {1'b0, g_q} + (DIST_W + 1)'(ew);
  assign nd_c   = nd_sum[DIST_W] ? DIST_INF : nd_sum[DIST_W-1:0];
  assign h_eff  = h_rv_q ? h_rd_q : '0;
  assign d_eff  = d_rv_q ? d_rd_q : DIST_INF;
  assign f_sum  = {1'b0, nd_q} + (DIST_W + 1)'(h_eff);
  assign f_c    = f_sum[DIST_W] ? DIST_INF : f_sum[DIST_W-1:0];
  assign improve = d_eff > nd_q;
  assign q_full  = (q_cnt_q == QueueMax);

  assign h_raddr = cmd_i.search_init ? a_q[VA_W-1:0] : n_c[VA_W-1:0];
  assign d_raddr = cmd_i.g_read ? v_q[VA_W-1:0] : n_c[VA_W-1:0];
  assign q_raddr = cmd_i.rm_read ? QA_W'(q_cnt_q - 1'b1) : sidx_q[QA_W-1:0];

  always_comb begin
    q_we    = 1'b0;
    q_waddr = q_cnt_q[QA_W-1:0];
    q_wdata = '0;
    if (cmd_i.init_push) begin
      q_we    = !q_full;
      q_wdata = {DIST_W'(h_eff), a_q};
    end else if (cmd_i.relax) begin
      q_we    = improve && !q_full;
      q_wdata = {f_c, n_q};
    end else if (cmd_i.rm_write) begin
      q_we    = 1'b1;
      q_waddr = bidx_q;
      q_wdata = q_rd_q;
    end
  end

  always_comb begin
    d_we      = 1'b0;
    d_waddr   = n_q[VA_W-1:0];
    d_wdata   = nd_q;
    par_wdata = v_q;
    if (cmd_i.search_init) begin
      d_we      = 1'b1;
      d_waddr   = a_q[VA_W-1:0];
      d_wdata   = '0;
      par_wdata = a_q;
    end else if (cmd_i.relax) begin
      d_we = improve;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      a_q    <= vertex_a_i;
      b_q    <= vertex_b_i;
      w_q    <= edge_weight_i;
      hv_q   <= heuristic_value_i;
    end
    if (cmd_i.edge_write) begin
      edge_mem_q[edge_cnt_q[EA_W-1:0]] <= {a_q, b_q, w_q};
    end
    edge_rd_q <= edge_mem_q[eidx_q[EA_W-1:0]];
    if (cmd_i.h_write) begin
      h_mem_q[a_q[VA_W-1:0]] <= hv_q;
    end
    h_rd_q <= h_mem_q[h_raddr];
    if (d_we) begin
      d_mem_q[d_waddr]   <= d_wdata;
      par_mem_q[d_waddr] <= par_wdata;
    end
    d_rd_q   <= d_mem_q[d_raddr];
    par_rd_q <= par_mem_q[cur_q[VA_W-1:0]];
    if (q_we) begin
      q_mem_q[q_waddr] <= q_wdata;
    end
    q_rd_q <= q_mem_q[q_raddr];
    if (cmd_i.path_write) begin
      path_mem_q[pcnt_q[VA_W-1:0]] <= cur_q;
    end
    pm_rd_q <= path_mem_q[k_q[VA_W-1:0]];
    if (cmd_i.scan_start) begin
      best_q <= '1;
    end else if (srv_q && (q_rd_q < best_q)) begin
      best_q <= q_rd_q;
    end
    if (cmd_i.scan_run) begin
      sidx_d1_q <= sidx_q[QA_W-1:0];
    end
    if (cmd_i.rm_write) begin
      v_q <= best_q[VW-1:0];
    end
    if (cmd_i.g_latch) begin
      g_q <= d_eff;
    end
    if (cmd_i.edge_check) begin
      n_q  <= n_c;
      nd_q <= nd_c;
    end
    if (cmd_i.path_init) begin
      cur_q <= b_q;
    end else if (cmd_i.par_load) begin
      cur_q <= par_rd_q;
    end
    if (cmd_i.out_load) begin
      pv_q   <= cmd_i.out_path ? pm_rd_q : '0;
      sc_q   <= steps_q;
      st_q   <= cmd_i.out_path ? STATUS_FOUND : cmd_i.out_status;
      last_q <= cmd_i.out_path ? (k_q == '0) : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_cnt_q  <= '0;
      eidx_q      <= '0;
      h_vld_q     <= '0;
      h_rv_q      <= 1'b0;
      d_vld_q     <= '0;
      d_rv_q      <= 1'b0;
      vis_q       <= '0;
      q_cnt_q     <= '0;
      sidx_q      <= '0;
      srv_q       <= 1'b0;
      bidx_q      <= '0;
      steps_q     <= '0;
      pcnt_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.edge_clear) begin
        edge_cnt_q <= '0;
      end else if (cmd_i.edge_write) begin
        edge_cnt_q <= edge_cnt_q + 1'b1;
      end
      if (cmd_i.g_latch) begin
        eidx_q <= '0;
      end else if (cmd_i.eidx_inc) begin
        eidx_q <= eidx_q + 1'b1;
      end
      if (cmd_i.h_write) begin
        h_vld_q[a_q[VA_W-1:0]] <= 1'b1;
      end
      h_rv_q <= h_vld_q[h_raddr];
      if (cmd_i.search_init) begin
        d_vld_q <= MAX_VERTICES'(1) << a_q[VA_W-1:0];
        vis_q <= '0;
      end else begin
        if (d_we) begin
          d_vld_q[d_waddr] <= 1'b1;
        end
        if (cmd_i.g_latch) begin
          vis_q[v_q[VA_W-1:0]] <= 1'b1;
        end
      end
      d_rv_q <= d_vld_q[d_raddr];
      if (cmd_i.search_init) begin
        q_cnt_q <= '0;
      end else if (q_we && !cmd_i.rm_write) begin
        q_cnt_q <= q_cnt_q + 1'b1;
      end else if (cmd_i.rm_write) begin
        q_cnt_q <= q_cnt_q - 1'b1;
      end
      if (cmd_i.scan_start) begin
        sidx_q <= '0;
        srv_q  <= 1'b0;
        bidx_q <= '0;
      end else begin
        if (cmd_i.scan_run && (sidx_q < q_cnt_q)) begin
          sidx_q <= sidx_q + 1'b1;
          srv_q  <= 1'b1;
        end else begin
          srv_q <= 1'b0;
        end
        if (srv_q && (q_rd_q < best_q)) begin
          bidx_q <= sidx_d1_q;
        end
      end
      if (cmd_i.capture) begin
        steps_q <= '0;
      end else if (cmd_i.step_inc && (steps_q != STEP_MAX)) begin
        steps_q <= steps_q + 1'b1;
      end
      if (cmd_i.path_init) begin
        pcnt_q <= '0;
      end else if (cmd_i.path_write) begin
        pcnt_q <= pcnt_q + 1'b1;
      end
      if (cmd_i.path_write) begin
        k_q <= pcnt_q;
      end else if (cmd_i.emit_dec) begin
        k_q <= k_q - 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.func       = func_q;
    sts_o.a_bad      = ({1'b0, a_q} >= VLimit);
    sts_o.b_bad      = ({1'b0, b_q} >= VLimit);
    sts_o.edge_full  = (edge_cnt_q == EdgeMax);
    sts_o.q_empty    = (q_cnt_q == '0);
    sts_o.scan_done  = (sidx_q == q_cnt_q) && !srv_q;
    sts_o.v_bad      = ({1'b0, v_q} >= VLimit);
    sts_o.v_is_tgt   = (v_q == b_q);
    sts_o.edges_done = (eidx_q == edge_cnt_q);
    sts_o.match_ok   = e_match && ({1'b0, n_c} < VLimit) && !vis_q[n_c[VA_W-1:0]];
    sts_o.cur_is_src = (cur_q == a_q);
    sts_o.path_full  = (pcnt_q == PathLast);
    sts_o.par_bad    = ({1'b0, par_rd_q} >= VLimit);
    sts_o.emit_last  = (k_q == '0);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign path_vertex_o = pv_q;
  assign step_count_o  = sc_q;
  assign status_o      = st_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

>>> rtl/astar_shortest_path_core.sv
// Load words (edge, heuristic, clear) give no result unless the edge store is full. A search
// scans the whole open queue serially for each pop and walks all stored edges for each
// expanded vertex, checking the unvisited neighbors; the path is then emitted one vertex
// per result word.
// Reset is asynchronous and active low; it empties the edge store, zeroes heuristics and
// idles the controller, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module astar_shortest_path_core #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int QUEUE_DEPTH  = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [asp_pkg::VW-1:0]        vertex_a_i,
  input  logic [asp_pkg::VW-1:0]        vertex_b_i,
  input  logic [asp_pkg::WGT_W-1:0]     edge_weight_i,
  input  logic [asp_pkg::HEUR_W-1:0]    heuristic_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [asp_pkg::VW-1:0]        path_vertex_o,
  output logic [asp_pkg::STEP_W-1:0]    step_count_o,
  output logic [1:0]                    status_o,
  output logic                          last_o
);
  import asp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  asp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  asp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .func_i            (func_i),
    .vertex_a_i        (vertex_a_i),
    .vertex_b_i        (vertex_b_i),
    .edge_weight_i     (edge_weight_i),
    .heuristic_value_i (heuristic_value_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .path_vertex_o     (path_vertex_o),
    .step_count_o      (step_count_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

>>> dv/astar_shortest_path_core_test.sv
`timescale 1ns / 1ps

module astar_shortest_path_core_test;
  import asp_pkg::*;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam int QD = 512;
  localparam int QUIET_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int CALM_TAIL = 40;
  localparam int STIM_TARGET = 260;

  typedef struct packed {
    logic [VW-1:0]     pv;
    logic [STEP_W-1:0] steps;
    logic [1:0]        st;
    logic              lst;
  } path_word_t;

  typedef struct packed {
    logic [1:0]        fn;
    logic [VW-1:0]     va;
    logic [VW-1:0]     vb;
    logic [WGT_W-1:0]  wt;
    logic [HEUR_W-1:0] hv;
    logic              typed;
    path_word_t        res;
  } cmd_word_t;

  localparam path_word_t NO_RES = '0;

  cmd_word_t directed_tbl [18] = '{
    '{FUNC_SEARCH,    6'd3,  6'd3,  16'd0,     16'd0,     1'b1, '{6'd3, 10'd0, STATUS_FOUND, 1'b1}},
    '{FUNC_SEARCH,    6'd0,  6'd1,  16'd0,     16'd0,     1'b1, '{6'd0, 10'd1, STATUS_UNREACH, 1'b1}},
    '{FUNC_LOAD_HEUR, 6'd63, 6'd0,  16'd0,     16'hFFFF,  1'b0, NO_RES},
    '{FUNC_LOAD_HEUR, 6'd0,  6'd63, 16'hFFFF,  16'd0,     1'b0, NO_RES},
    '{FUNC_LOAD_EDGE, 6'd0,  6'd1,  16'd0,     16'hFFFF,  1'b0, NO_RES},
    '{FUNC_LOAD_EDGE, 6'd1,  6'd2,  16'hFFFF,  16'd0,     1'b0, NO_RES},
    '{FUNC_LOAD_EDGE, 6'd2,  6'd63, 16'd1,     16'd0,     1'b0, NO_RES},
    '{FUNC_LOAD_EDGE, 6'd63, 6'd63, 16'd7,     16'd0,     1'b0, NO_RES},
    '{FUNC_LOAD_HEUR, 6'd2,  6'd0,  16'd0,     16'd5,     1'b0, NO_RES},
    '{FUNC_SEARCH,    6'd0,  6'd63, 16'd0,     16'd0,     1'b0, NO_RES},
    '{FUNC_SEARCH,    6'd63, 6'd0,  16'hFFFF,  16'hFFFF,  1'b0, NO_RES},
    '{FUNC_LOAD_EDGE, 6'd0,  6'd2,  16'hFFFF,  16'd0,     1'b0, NO_RES},
    '{FUNC_SEARCH,    6'd0,  6'd2,  16'd0,     16'd0,     1'b0, NO_RES},
    '{FUNC_CLEAR,     6'd63, 6'd63, 16'hFFFF,  16'hFFFF,  1'b0, NO_RES},
    '{FUNC_SEARCH,    6'd0,  6'd2,  16'd0,     16'd0,     1'b1, '{6'd0, 10'd1, STATUS_UNREACH, 1'b1}},
    '{FUNC_LOAD_HEUR, 6'd63, 6'd0,  16'd0,     16'd0,     1'b0, NO_RES},
    '{FUNC_LOAD_EDGE, 6'd63, 6'd0,  16'hFFFF,  16'd0,     1'b0, NO_RES},
    '{FUNC_SEARCH,    6'd63, 6'd0,  16'd0,     16'd0,     1'b0, NO_RES}
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] func_i;
  logic [VW-1:0] vertex_a_i;
  logic [VW-1:0] vertex_b_i;
  logic [WGT_W-1:0] edge_weight_i;
  logic [HEUR_W-1:0] heuristic_value_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [VW-1:0] path_vertex_o;
  logic [STEP_W-1:0] step_count_o;
  logic [1:0] status_o;
  logic last_o;

  astar_shortest_path_core DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .func_i(func_i),
    .vertex_a_i(vertex_a_i),
    .vertex_b_i(vertex_b_i),
    .edge_weight_i(edge_weight_i),
    .heuristic_value_i(heuristic_value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .path_vertex_o(path_vertex_o),
    .step_count_o(step_count_o),
    .status_o(status_o),
    .last_o(last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mirror of the search engine state.
  logic [EDGE_W-1:0] edge_mem [NE];
  int unsigned edge_cnt;
  logic [HEUR_W-1:0] heur_mem [NV];
  logic [DIST_W-1:0] dist_mem [NV];
  logic [VW-1:0] parent_mem [NV];
  bit seen_mem [NV];
  logic [QKEY_W-1:0] open_mem [QD];
  int unsigned open_cnt;

  cmd_word_t stim_q [$];
  path_word_t path_exp_q [$];
  int unsigned errors;

  function automatic logic [DIST_W-1:0] dist_add(logic [DIST_W-1:0] x, logic [DIST_W-1:0] y);
    logic [DIST_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[DIST_W] ? DIST_INF : s[DIST_W-1:0];
  endfunction

  task automatic open_push(logic [DIST_W-1:0] f, logic [VW-1:0] v);
    if (open_cnt < QD) begin
      open_mem[open_cnt] = {f, v};
      open_cnt++;
    end
  endtask

  task automatic try_relax(logic [VW-1:0] n, logic [VW-1:0] v, logic [DIST_W-1:0] g,
                           logic [WGT_W-1:0] w);
    logic [DIST_W-1:0] nd;
    if (!seen_mem[n]) begin
      nd = dist_add(g, {8'd0, w});
      if (dist_mem[n] > nd) begin
        dist_mem[n] = nd;
        parent_mem[n] = v;
        open_push(dist_add(nd, {8'd0, heur_mem[n]}), n);
      end
    end
  endtask

  task automatic run_astar(logic [VW-1:0] src, logic [VW-1:0] tgt, output path_word_t res [$]);
    logic [STEP_W-1:0] steps;
    logic [VW-1:0] v;
    logic [VW-1:0] cur;
    logic [DIST_W-1:0] g;
    logic [QKEY_W-1:0] key;
    logic [VW-1:0] route [NV];
    int unsigned best;
    int unsigned n;
    bit found;
    path_word_t one;
    res = {};
    steps = '0;
    found = 1'b0;
    for (int i = 0; i < NV; i++) begin
      dist_mem[i] = DIST_INF;
      seen_mem[i] = 1'b0;
    end
    open_cnt = 0;
    dist_mem[src] = '0;
    parent_mem[src] = src;
    open_push({8'd0, heur_mem[src]}, src);
    while (open_cnt > 0) begin
      best = 0;
      for (int unsigned i = 1; i < open_cnt; i++)
        if (open_mem[i] < open_mem[best]) best = i;
      key = open_mem[best];
      open_cnt--;
      open_mem[best] = open_mem[open_cnt];
      v = key[VW-1:0];
      g = dist_mem[v];
      seen_mem[v] = 1'b1;
      if (v == tgt) begin
        found = 1'b1;
        break;
      end
      for (int unsigned i = 0; i < edge_cnt; i++) begin
        if (edge_mem[i][27:22] == v) try_relax(edge_mem[i][21:16], v, g, edge_mem[i][15:0]);
        if (edge_mem[i][21:16] == v) try_relax(edge_mem[i][27:22], v, g, edge_mem[i][15:0]);
      end
      if (steps != STEP_MAX) steps++;
    end
    if (!found) begin
      one = '{'0, steps, STATUS_UNREACH, 1'b1};
      res.insert(res.size(), one);
    end else begin
      cur = tgt;
      n = 0;
      while (n < NV) begin
        route[n] = cur;
        n++;
        if (cur == src) break;
        cur = parent_mem[cur];
      end
      for (int unsigned k = 0; k < n; k++) begin
        one = '{route[n-1-k], steps, STATUS_FOUND, (k == n - 1)};
        res.insert(res.size(), one);
      end
    end
  endtask

  task automatic apply_word(cmd_word_t c);
    path_word_t res [$];
    path_word_t one;
    res = {};
    case (c.fn)
      FUNC_LOAD_EDGE: begin
        if (edge_cnt >= NE) begin
          one = '{'0, '0, STATUS_FULL, 1'b1};
          res.insert(res.size(), one);
        end else begin
          edge_mem[edge_cnt] = {c.va, c.vb, c.wt};
          edge_cnt++;
        end
      end
      FUNC_LOAD_HEUR: heur_mem[c.va] = c.hv;
      FUNC_SEARCH: run_astar(c.va, c.vb, res);
      default: edge_cnt = 0;
    endcase
    if (c.typed) path_exp_q.insert(path_exp_q.size(), c.res);
    else foreach (res[i]) path_exp_q.insert(path_exp_q.size(), res[i]);
  endtask

  task automatic queue_word(logic [1:0] fn, logic [VW-1:0] a, logic [VW-1:0] b,
                            logic [WGT_W-1:0] w, logic [HEUR_W-1:0] h);
    cmd_word_t c;
    c = '{fn, a, b, w, h, 1'b0, NO_RES};
    stim_q.insert(stim_q.size(), c);
  endtask

  function automatic logic [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WGT_W'($urandom);
      2: return '1;
      default: return WGT_W'($urandom_range(1, 60));
    endcase
  endfunction

  function automatic logic [HEUR_W-1:0] pick_heur();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return HEUR_W'($urandom);
      2, 3: return '0;
      default: return HEUR_W'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic build_stimulus();
    int unsigned nv;
    int unsigned base;
    int unsigned ne;
    int unsigned k;
    foreach (directed_tbl[i]) stim_q.insert(stim_q.size(), directed_tbl[i]);
    // Fill the edge store past its end on a few vertices, then search the dense graph.
    queue_word(FUNC_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i < NE + 3; i++)
      queue_word(FUNC_LOAD_EDGE, VW'($urandom_range(0, 7)), VW'($urandom_range(0, 7)),
                 WGT_W'($urandom_range(1, 100)), HEUR_W'($urandom));
    queue_word(FUNC_SEARCH, 6'd0, 6'd7, '0, '0);
    queue_word(FUNC_SEARCH, 6'd5, 6'd2, '0, '0);
    queue_word(FUNC_CLEAR, '0, '0, '0, '0);
    while (stim_q.size() < STIM_TARGET) begin
      if ($urandom_range(0, 9) < 8) begin
        nv = $urandom_range(3, 16);
        base = $urandom_range(0, NV - nv);
        ne = $urandom_range(nv - 1, 2 * nv);
        queue_word(FUNC_CLEAR, VW'($urandom), VW'($urandom), WGT_W'($urandom), HEUR_W'($urandom));
        for (int i = 0; i < ne; i++)
          queue_word(FUNC_LOAD_EDGE, VW'(base + $urandom_range(0, nv - 1)),
                     VW'(base + $urandom_range(0, nv - 1)), pick_weight(), HEUR_W'($urandom));
        for (int i = 0; i < nv; i++)
          if ($urandom_range(0, 1))
            queue_word(FUNC_LOAD_HEUR, VW'(base + i), VW'($urandom), WGT_W'($urandom),
                       pick_heur());
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
          queue_word(FUNC_SEARCH, VW'(base + $urandom_range(0, nv - 1)),
                     VW'(base + $urandom_range(0, nv - 1)), WGT_W'($urandom), HEUR_W'($urandom));
      end else begin
        k = $urandom_range(1, 5);
        for (int i = 0; i < k; i++)
          queue_word(2'($urandom), VW'($urandom), VW'($urandom), WGT_W'($urandom),
                     HEUR_W'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned in_gap;
    int unsigned out_gap;
    int unsigned quiet;
    int unsigned drain;
    bit in_taken;
    bit out_taken;
    bit calm;
    bit timed_out;
    path_word_t got;
    path_word_t want;
    cmd_word_t cur;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = '0;
    vertex_a_i = '0;
    vertex_b_i = '0;
    edge_weight_i = '0;
    heuristic_value_i = '0;
    out_stall_i = 1'b0;
    errors = 0;
    edge_cnt = 0;
    open_cnt = 0;
    for (int i = 0; i < NV; i++) begin
      heur_mem[i] = '0;
      dist_mem[i] = DIST_INF;
      parent_mem[i] = '0;
      seen_mem[i] = 1'b0;
    end
    in_gap = 0;
    out_gap = 0;
    quiet = 0;
    drain = 0;
    in_taken = 1'b0;
    timed_out = 1'b0;
    build_stimulus();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    forever begin
      @(negedge clk_i);
      calm = stim_q.size() < CALM_TAIL;
      if (in_valid_i && !in_taken) begin
        // Stalled word stays on the bus.
      end else if (in_gap > 0) begin
        in_valid_i = 1'b0;
        in_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_valid_i = 1'b0;
        in_gap = $urandom_range(0, 3);
      end else if (stim_q.size() > 0) begin
        cur = stim_q[0];
        in_valid_i = 1'b1;
        func_i = cur.fn;
        vertex_a_i = cur.va;
        vertex_b_i = cur.vb;
        edge_weight_i = cur.wt;
        heuristic_value_i = cur.hv;
      end else begin
        in_valid_i = 1'b0;
      end
      if (out_gap > 0) begin
        out_stall_i = 1'b1;
        out_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i = 1'b1;
        out_gap = $urandom_range(0, 3);
      end else begin
        out_stall_i = 1'b0;
      end
      #4;
      in_taken = in_valid_i && !in_stall_o;
      out_taken = out_valid_o && !out_stall_i;
      got = '{path_vertex_o, step_count_o, status_o, last_o};
      @(posedge clk_i);
      if (in_taken) apply_word(stim_q.pop_front());
      if (out_taken) begin
        if (path_exp_q.size() == 0) begin
          $error("unexpected result word: path_vertex %0d status %0d", got.pv, got.st);
          errors++;
        end else begin
          want = path_exp_q.pop_front();
          if (got.pv !== want.pv) begin
            $error("path_vertex expected %0d actual %0d", want.pv, got.pv);
            errors++;
          end
          if (got.steps !== want.steps) begin
            $error("step_count expected %0d actual %0d", want.steps, got.steps);
            errors++;
          end
          if (got.st !== want.st) begin
            $error("status expected %0d actual %0d", want.st, got.st);
            errors++;
          end
          if (got.lst !== want.lst) begin
            $error("last expected %0d actual %0d", want.lst, got.lst);
            errors++;
          end
        end
      end
      quiet = (in_taken || out_taken) ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        timed_out = 1'b1;
        break;
      end
      if (stim_q.size() == 0 && path_exp_q.size() == 0 && (in_taken || !in_valid_i)) begin
        drain++;
        if (drain >= DRAIN_CYCLES) break;
      end else begin
        drain = 0;
      end
    end
    if (!timed_out && errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/asp_pkg.sv
rtl/asp_ctrl.sv
rtl/asp_datapath.sv
rtl/astar_shortest_path_core.sv
dv/astar_shortest_path_core_test.sv
